// File: sv/fcpm_pkg.sv
`default_nettype none

package fcpm_pkg;

  localparam int PIX_W  = 32;
  localparam int FS_W   = 31;
  localparam int Q_W    = 11;
  localparam int MULT_W = FS_W + Q_W;
  localparam int COMP_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 1'b1;

  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 31'd2560;
  localparam logic [Q_W-1:0]    K_COLOR        = 11'd1536;
  localparam logic [Q_W-1:0]    K_MONO         = 11'd255;
  localparam logic [COMP_W-1:0] COMP_MAX       = 8'hFF;
  localparam logic [COMP_W-1:0] COMP_ZERO      = 8'h00;

  typedef enum logic [1:0] {
    PAL_COLOR = 2'd0,
    PAL_MONO  = 2'd1,
    PAL_INV   = 2'd2,
    PAL_OFF   = 2'd3
  } pal_mode_t;

  typedef struct packed {
    pal_mode_t mode;
    logic      neg;
    logic      high;
  } fcpm_ctl_t;

endpackage

`default_nettype wire

// File: sv/fcpm_front.sv
`default_nettype none

module fcpm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fcpm_pkg::PIX_W-1:0]   in_pixel,
  input  wire logic [fcpm_pkg::FS_W-1:0]    full_scale,
  input  wire fcpm_pkg::pal_mode_t          mode,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output fcpm_pkg::fcpm_ctl_t               out_ctl,
  output logic [fcpm_pkg::MULT_W-1:0]       out_num
);
  import fcpm_pkg::*;

  logic            a_valid;
  fcpm_ctl_t       a_ctl;
  logic [FS_W-1:0] a_x;
  logic [Q_W-1:0]  a_k;
  logic            a_ready;
  logic            b_ready;
  logic            neg;
  logic [FS_W-1:0] val;
  logic            high;
  logic [FS_W-1:0] x;
  logic [Q_W-1:0]  k;
  logic [MULT_W-1:0] prod;

  // Inverted mono divides (full_scale - val); the others divide val.
  always_comb begin
    neg  = in_pixel[PIX_W-1];
    val  = in_pixel[FS_W-1:0];
    high = !neg && (val >= full_scale);
    x    = (mode == PAL_INV) ? (full_scale - val) : val;
    k    = (mode == PAL_COLOR) ? K_COLOR : K_MONO;
  end

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign prod     = MULT_W'(a_x) * MULT_W'(a_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_ctl <= '{mode: mode, neg: neg, high: high};
      a_x   <= x;
      a_k   <= k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      out_ctl <= a_ctl;
      out_num <= prod;
    end
  end

endmodule

`default_nettype wire

// File: sv/fcpm_div_step.sv
`default_nettype none

module fcpm_div_step (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [fcpm_pkg::FS_W-1:0] full_scale,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire fcpm_pkg::fcpm_ctl_t       in_ctl,
  input  wire logic [fcpm_pkg::FS_W-1:0] in_rem,
  input  wire logic [fcpm_pkg::Q_W-1:0]  in_bits,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output fcpm_pkg::fcpm_ctl_t            out_ctl,
  output logic [fcpm_pkg::FS_W-1:0]      out_rem,
  output logic [fcpm_pkg::Q_W-1:0]       out_bits
);
  import fcpm_pkg::*;

  logic [FS_W:0]   trial;
  logic [FS_W:0]   diff;
  logic            ge;
  logic [FS_W-1:0] rem_next;
  logic [Q_W-1:0]  bits_next;

  // The numerator's low bits shift out at the top while quotient bits shift in below.
  always_comb begin
    trial     = {in_rem, in_bits[Q_W-1]};
    diff      = trial - {1'b0, full_scale};
    ge        = trial >= {1'b0, full_scale};
    rem_next  = ge ? diff[FS_W-1:0] : trial[FS_W-1:0];
    bits_next = {in_bits[Q_W-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl  <= in_ctl;
      out_rem  <= rem_next;
      out_bits <= bits_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/fcpm_palette.sv
`default_nettype none

module fcpm_palette (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire fcpm_pkg::fcpm_ctl_t         in_ctl,
  input  wire logic [fcpm_pkg::Q_W-1:0]    in_q,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fcpm_pkg::COMP_W-1:0]      red,
  output logic [fcpm_pkg::COMP_W-1:0]      green,
  output logic [fcpm_pkg::COMP_W-1:0]      blue
);
  import fcpm_pkg::*;

  logic [2:0]          seg;
  logic [COMP_W-1:0]   f;
  logic [COMP_W-1:0]   f_down;
  logic [2*COMP_W:0]   half_lo;
  logic [2*COMP_W:0]   half_hi;
  logic [COMP_W-1:0]   r_next;
  logic [COMP_W-1:0]   g_next;
  logic [COMP_W-1:0]   b_next;

  always_comb begin
    seg     = in_q[Q_W-1:COMP_W];
    f       = in_q[COMP_W-1:0];
    f_down  = (f == COMP_ZERO) ? COMP_ZERO : f - 8'd1;
    half_lo = {9'd0, f} * 17'd255;
    half_hi = {9'd1, f} * 17'd255;
    r_next  = COMP_ZERO;
    g_next  = COMP_ZERO;
    b_next  = COMP_ZERO;
    case (in_ctl.mode)
      PAL_COLOR: begin
        if (in_ctl.neg) begin
          r_next = COMP_ZERO;
        end else if (in_ctl.high) begin
          r_next = COMP_MAX;
          g_next = COMP_MAX;
          b_next = COMP_MAX;
        end else begin
          case (seg)
            3'd0: begin
              b_next = f_down;
            end
            3'd1: begin
              r_next = f_down;
              b_next = COMP_MAX;
            end
            3'd2: begin
              r_next = COMP_MAX;
              b_next = COMP_MAX - f;
            end
            3'd3: begin
              r_next = COMP_MAX;
              g_next = half_lo[2*COMP_W:9];
            end
            3'd4: begin
              r_next = COMP_MAX;
              g_next = half_hi[2*COMP_W:9];
            end
            default: begin
              r_next = COMP_MAX;
              g_next = COMP_MAX;
              b_next = f_down;
            end
          endcase
        end
      end
      PAL_MONO: begin
        r_next = in_ctl.neg ? COMP_ZERO : (in_ctl.high ? COMP_MAX : f);
        g_next = r_next;
        b_next = r_next;
      end
      PAL_INV: begin
        r_next = in_ctl.neg ? COMP_MAX : (in_ctl.high ? COMP_ZERO : f);
        g_next = r_next;
        b_next = r_next;
      end
      default: begin
        r_next = COMP_ZERO;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/false_colour_pixel_map_unit.sv
// Pipeline: two front stages (classify and multiply), eleven divider stages of one quotient
// bit each and one palette stage lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle unless stalled; each stage holds one beat until the next is free.
// Reset (rst, synchronous) empties the pipeline and sets full_scale to 2560, mode to colour.
`default_nettype none

module false_colour_pixel_map_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fcpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fcpm_pkg::FS_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // [31:0] pixel_value
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import fcpm_pkg::*;

  logic [FS_W-1:0] full_scale;
  pal_mode_t       palette_mode;

  logic            stage_valid [Q_W+1];
  logic            stage_ready [Q_W+1];
  fcpm_ctl_t       stage_ctl   [Q_W+1];
  logic [FS_W-1:0] stage_rem   [Q_W+1];
  logic [Q_W-1:0]  stage_bits  [Q_W+1];
  logic [MULT_W-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale   <= FULL_SCALE_RST;
      palette_mode <= PAL_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SCALE:   full_scale   <= cfg_data;
        CFG_PALETTE_MODE: palette_mode <= pal_mode_t'(cfg_data[1:0]);
        default:          full_scale   <= full_scale;
      endcase
    end
  end

  fcpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_pixel   (s_axis_tdata),
    .full_scale (full_scale),
    .mode       (palette_mode),
    .out_valid  (stage_valid[0]),
    .out_ready  (stage_ready[0]),
    .out_ctl    (stage_ctl[0]),
    .out_num    (num)
  );

  assign stage_rem[0]  = num[MULT_W-1:Q_W];
  assign stage_bits[0] = num[Q_W-1:0];

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    fcpm_div_step u_step (
      .clk        (clk),
      .rst        (rst),
      .full_scale (full_scale),
      .in_valid   (stage_valid[i]),
      .in_ready   (stage_ready[i]),
      .in_ctl     (stage_ctl[i]),
      .in_rem     (stage_rem[i]),
      .in_bits    (stage_bits[i]),
      .out_valid  (stage_valid[i+1]),
      .out_ready  (stage_ready[i+1]),
      .out_ctl    (stage_ctl[i+1]),
      .out_rem    (stage_rem[i+1]),
      .out_bits   (stage_bits[i+1])
    );
  end

  fcpm_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[Q_W]),
    .in_ready  (stage_ready[Q_W]),
    .in_ctl    (stage_ctl[Q_W]),
    .in_q      (stage_bits[Q_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red       (m_axis_tdata[7:0]),
    .green     (m_axis_tdata[15:8]),
    .blue      (m_axis_tdata[23:16])
  );

  // A ready sink leaves every stage free to move.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // The colour quotient stays below six segments.
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[Q_W] && stage_ctl[Q_W].mode == PAL_COLOR &&
     !stage_ctl[Q_W].neg && !stage_ctl[Q_W].high)
    |-> (stage_bits[Q_W][Q_W-1:Q_W-2] != 2'b11))
    else $error("colour quotient out of range");

  // The grey ramp quotient fits in one component.
  a_mono_range: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[Q_W] &&
     (stage_ctl[Q_W].mode == PAL_MONO || stage_ctl[Q_W].mode == PAL_INV) &&
     !stage_ctl[Q_W].neg && !stage_ctl[Q_W].high)
    |-> (stage_bits[Q_W][Q_W-1:COMP_W] == '0))
    else $error("grey quotient out of range");

endmodule

`default_nettype wire

// File: tb/pixel_colour_checker.sv
module pixel_colour_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcpm_pkg::FS_W-1:0]      cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] pixel_value
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [23:0]                    m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output int                             fail_count,
  output int                             colours_due
);
  import fcpm_pkg::*;

  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgb_t;

  logic [FS_W-1:0] scale;
  pal_mode_t       mode;
  rgb_t            colour_q[$];

  function automatic logic [COMP_W-1:0] ramp(logic [63:0] num, logic [63:0] den);
    logic [63:0] t;
    t = (64'd255 * num) / den;
    return t[COMP_W-1:0];
  endfunction

  function automatic rgb_t heat_colour(logic [31:0] pix, logic [FS_W-1:0] fs, pal_mode_t pm);
    logic              neg;
    logic              at_top;
    logic [63:0]       q;
    logic [2:0]        seg;
    logic [7:0]        f;
    logic [COMP_W-1:0] lvl;
    rgb_t              c;
    neg = pix[31];
    at_top = !neg && (pix[30:0] >= fs);
    c = '0;
    case (pm)
      PAL_COLOR: begin
        if (at_top) begin
          c = '{COMP_MAX, COMP_MAX, COMP_MAX};
        end else if (!neg) begin
          q = (64'd1536 * 64'(pix)) / 64'(fs);
          seg = q[10:8];
          f = q[7:0];
          case (seg)
            3'd0: c = '{ramp(64'(f), 64'd256), COMP_ZERO, COMP_ZERO};
            3'd1: c = '{COMP_MAX, COMP_ZERO, ramp(64'(f), 64'd256)};
            3'd2: c = '{ramp(64'd256 - 64'(f), 64'd256), COMP_ZERO, COMP_MAX};
            3'd3: c = '{COMP_ZERO, ramp(64'(f), 64'd512), COMP_MAX};
            3'd4: c = '{COMP_ZERO, ramp(64'd256 + 64'(f), 64'd512), COMP_MAX};
            default: c = '{ramp(64'(f), 64'd256), COMP_MAX, COMP_MAX};
          endcase
        end
      end
      PAL_MONO: begin
        lvl = neg ? COMP_ZERO : at_top ? COMP_MAX : ramp(64'(pix), 64'(fs));
        c = '{lvl, lvl, lvl};
      end
      PAL_INV: begin
        lvl = neg ? COMP_MAX : at_top ? COMP_ZERO : ramp(64'(fs) - 64'(pix), 64'(fs));
        c = '{lvl, lvl, lvl};
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  task automatic check_field(string name, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    colours_due = 0;
  end

  always @(posedge clk) begin : watch
    rgb_t want;
    rgb_t got;
    if (rst) begin
      scale = FULL_SCALE_RST;
      mode = PAL_COLOR;
      colour_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        colour_q.push_back(heat_colour(s_axis_tdata, scale, mode));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (colour_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = colour_q.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FULL_SCALE)
          scale = cfg_data;
        else if (cfg_index == CFG_PALETTE_MODE)
          mode = pal_mode_t'(cfg_data[1:0]);
      end
    end
    colours_due = colour_q.size();
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  import fcpm_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FULL_SCALE;
  logic [FS_W-1:0]      cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // [31:0] pixel_value
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [23:0]          m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  int                   fail_count;
  int                   colours_due;
  logic [FS_W-1:0]      cur_scale = FULL_SCALE_RST;
  bit                   send_quiet = 1'b0;
  bit                   take_quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  false_colour_pixel_map_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pixel_colour_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .colours_due   (colours_due)
  );

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Most pixels land inside the palette range so that every segment is exercised.
  function automatic logic [31:0] draw_pixel(logic [FS_W-1:0] fs);
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(0, 9);
    v = $urandom;
    if (fs == 0 || pick == 8) return v;
    if (pick == 7) begin
      v[31] = 1'b1;
      return v;
    end
    if (pick == 9) return $urandom_range(0, 15);
    if (pick == 6) return {1'b0, fs} + $urandom_range(0, 4) - 2;
    return $urandom_range(0, fs - 1);
  endfunction

  task automatic send_pixel(input logic [31:0] v);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (colours_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [FS_W-1:0] fs, input pal_mode_t pm);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FULL_SCALE;
    cfg_data <= fs;
    @(posedge clk);
    cfg_index <= CFG_PALETTE_MODE;
    cfg_data <= FS_W'(pm);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_scale = fs;
  endtask

  task automatic send_edges();
    send_pixel(32'd0);
    send_pixel(32'd1);
    send_pixel({1'b0, cur_scale} - 32'd1);
    send_pixel({1'b0, cur_scale});
    send_pixel({1'b0, cur_scale} + 32'd1);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) send_quiet = ($urandom_range(0, 2) == 0);
      send_pixel(draw_pixel(cur_scale));
    end
  endtask

  initial begin
    int gap;
    int beats;
    beats = 0;
    while (rst) @(posedge clk);
    forever begin
      if (beats % 50 == 0) take_quiet = ($urandom_range(0, 2) == 0);
      gap = draw_gap(take_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      beats++;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: full scale 2560 in colour mode, with each segment boundary.
    send_pixel(32'd0);    send_pixel(32'd1);
    send_pixel(32'd426);  send_pixel(32'd427);
    send_pixel(32'd853);  send_pixel(32'd854);
    send_pixel(32'd1279); send_pixel(32'd1280);
    send_pixel(32'd1706); send_pixel(32'd1707);
    send_pixel(32'd2133); send_pixel(32'd2134);
    send_pixel(32'd2559); send_pixel(32'd2560);
    send_pixel(32'd2561); send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h8000_0000); send_pixel(32'hFFFF_FFFF);
    run_random(100);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph)
        0: write_cfg(31'd1, PAL_COLOR);
        1: write_cfg(31'h7FFF_FFFF, PAL_COLOR);
        2: write_cfg('0, PAL_COLOR);
        3: write_cfg(FS_W'($urandom_range(1, 4096)), PAL_MONO);
        4: write_cfg(31'h7FFF_FFFF, PAL_MONO);
        5: write_cfg('0, PAL_MONO);
        6: write_cfg(31'd1, PAL_INV);
        7: write_cfg(FS_W'($urandom_range(1, 32'h7FFF_FFFF)), PAL_INV);
        8: write_cfg('0, PAL_INV);
        9: write_cfg(FS_W'($urandom_range(1, 32'h7FFF_FFFF)), PAL_OFF);
        10: write_cfg(FS_W'($urandom_range(1, 4096)), PAL_COLOR);
        default: write_cfg(FS_W'($urandom_range(1, 32'h7FFF_FFFF)), PAL_COLOR);
      endcase
      send_edges();
      run_random(90);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
